FILE: rtl/sfpa_pkg.sv
// Shared constants, codes and control/status types of the smallest-fit allocator.
`default_nettype none
package sfpa_pkg;

  // Table geometry
  localparam int BLOCK_COUNT = 64;
  localparam int SIZE_W      = 16;
  localparam int IDX_W       = $clog2(BLOCK_COUNT);
  localparam int CNT_W       = $clog2(BLOCK_COUNT + 1);

  // Fixed field widths of the ports
  localparam int INDEX_W  = 6;
  localparam int ACTIVE_W = 7;
  localparam int STATUS_W = 2;

  // Request modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_ALLOC = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_LOAD_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_GRANTED   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_FIT    = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;  // request taken this cycle
    logic issue;   // read one table entry for the scan
    logic emit;    // load the result register
  } sfpa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic limit_zero;  // no entry takes part in allocation
    logic last_issue;  // current scan entry is the last one
    logic out_free;    // result register can take a new result
  } sfpa_stat_t;

endpackage
`default_nettype wire

FILE: rtl/sfpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sfpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/sfpa_ctrl.sv
// Sequencer of the allocator: accept, entry scan, drain and result hand-off.
`default_nettype none
module sfpa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               mode,
  input  wire sfpa_pkg::sfpa_stat_t stat,
  output sfpa_pkg::sfpa_cmd_t     cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next state and command decode
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          if (mode == sfpa_pkg::MODE_ALLOC && !stat.limit_zero) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.last_issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read data is compared this cycle
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = stat.out_free;
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/sfpa_dp.sv
// Datapath: capacity RAM, entry marks, best-fit tracking and result register.
`default_nettype none
module sfpa_dp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire sfpa_pkg::sfpa_cmd_t            cmd,
  output sfpa_pkg::sfpa_stat_t                stat,
  input  wire logic                           mode,
  input  wire logic [sfpa_pkg::INDEX_W-1:0]   entry_index,
  input  wire logic [sfpa_pkg::SIZE_W-1:0]    size,
  input  wire logic                           cfg_write_en,
  input  wire logic [sfpa_pkg::ACTIVE_W-1:0]  cfg_write_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [sfpa_pkg::STATUS_W-1:0]  status,
  output logic      [sfpa_pkg::INDEX_W-1:0]   granted_index,
  output logic      [sfpa_pkg::SIZE_W-1:0]    leftover
);

  localparam int WIDE_W = sfpa_pkg::IDX_W + sfpa_pkg::INDEX_W;
  localparam int LIM_W  = sfpa_pkg::ACTIVE_W + sfpa_pkg::CNT_W;

  logic [sfpa_pkg::ACTIVE_W-1:0] active_blocks;
  logic [sfpa_pkg::BLOCK_COUNT-1:0] loaded;
  logic [sfpa_pkg::BLOCK_COUNT-1:0] occupied;

  logic                          is_alloc;
  logic [sfpa_pkg::SIZE_W-1:0]   req;
  logic [sfpa_pkg::CNT_W-1:0]    cnt;
  logic                          pipe_valid;
  logic                          pipe_elig;
  logic [sfpa_pkg::IDX_W-1:0]    pipe_idx;
  logic                          found;
  logic [sfpa_pkg::IDX_W-1:0]    best_idx;
  logic [sfpa_pkg::SIZE_W-1:0]   best_cap;

  logic [WIDE_W-1:0]             load_wide;
  logic                          load_in_range;
  logic                          load_we;
  logic [sfpa_pkg::IDX_W-1:0]    load_addr;
  logic [sfpa_pkg::IDX_W-1:0]    scan_addr;
  logic [LIM_W-1:0]              active_wide;
  logic [sfpa_pkg::CNT_W-1:0]    limit;
  logic [sfpa_pkg::SIZE_W-1:0]   rdata;
  logic                          better;

  // Load address, range check against the table size
  assign load_wide     = WIDE_W'(entry_index);
  assign load_in_range = load_wide < WIDE_W'(sfpa_pkg::BLOCK_COUNT);
  assign load_addr     = load_wide[sfpa_pkg::IDX_W-1:0];
  assign load_we       = cmd.accept && mode == sfpa_pkg::MODE_LOAD && load_in_range;
  assign scan_addr     = cnt[sfpa_pkg::IDX_W-1:0];

  // Active count saturates at the table size
  assign active_wide = LIM_W'(active_blocks);
  always_comb begin
    if (active_wide > LIM_W'(sfpa_pkg::BLOCK_COUNT)) begin
      limit = sfpa_pkg::CNT_W'(sfpa_pkg::BLOCK_COUNT);
    end else begin
      limit = active_wide[sfpa_pkg::CNT_W-1:0];
    end
  end

  assign stat.limit_zero = active_blocks == '0;
  assign stat.last_issue = (cnt + sfpa_pkg::CNT_W'(1)) == limit;
  assign stat.out_free   = !out_valid || out_ready;

  sfpa_ram #(
    .WIDTH(sfpa_pkg::SIZE_W),
    .DEPTH(sfpa_pkg::BLOCK_COUNT)
  ) u_cap_ram (
    .clk  (clk),
    .we   (load_we),
    .waddr(load_addr),
    .wdata(size),
    .raddr(scan_addr),
    .rdata(rdata)
  );

  // Strictly smaller wins, so ties keep the lower index of the ascending scan
  assign better = pipe_valid && pipe_elig && rdata >= req && (!found || rdata < best_cap);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_blocks <= '0;
    end else if (cfg_write_en) begin
      active_blocks <= cfg_write_data;
    end
  end

  // Entry marks: load frees an entry, a grant occupies it
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded   <= '0;
      occupied <= '0;
    end else begin
      if (load_we) begin
        loaded[load_addr]   <= 1'b1;
        occupied[load_addr] <= 1'b0;
      end
      if (cmd.emit && is_alloc && found) begin
        occupied[best_idx] <= 1'b1;
      end
    end
  end

  // Scan control and best-so-far tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      pipe_valid <= 1'b0;
      found      <= 1'b0;
    end else begin
      pipe_valid <= cmd.issue;
      if (cmd.accept) begin
        cnt   <= '0;
        found <= 1'b0;
      end else begin
        if (cmd.issue) begin
          cnt <= cnt + sfpa_pkg::CNT_W'(1);
        end
        if (better) begin
          found <= 1'b1;
        end
      end
    end
  end

  // Request and scan payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      is_alloc <= mode == sfpa_pkg::MODE_ALLOC;
      req      <= size;
    end
    pipe_elig <= loaded[scan_addr] && !occupied[scan_addr];
    pipe_idx  <= scan_addr;
    if (better) begin
      best_idx <= pipe_idx;
      best_cap <= rdata;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (!is_alloc) begin
        status        <= sfpa_pkg::STATUS_LOAD_DONE;
        granted_index <= '0;
        leftover      <= '0;
      end else if (found) begin
        status        <= sfpa_pkg::STATUS_GRANTED;
        granted_index <= sfpa_pkg::INDEX_W'(best_idx);
        leftover      <= best_cap - req;
      end else begin
        status        <= sfpa_pkg::STATUS_NO_FIT;
        granted_index <= '0;
        leftover      <= '0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/smallest_fit_partition_allocator_core.sv
// Top level of the smallest-fit partition allocator.
// A load request (mode 0) writes a partition size into one of 64 table entries and
// marks it free; after acceptance it goes straight to the result step, and the next
// request can be taken once that result is loaded. An allocate request (mode 1)
// scans entries 0 up to active_blocks-1 (capped at 64) one per cycle through the
// single read port of the capacity RAM, picks the smallest loaded free entry that
// fits (lowest index on ties), marks it occupied and returns its index and
// leftover, or a no-fit status. The scan is followed by a drain step for the last
// read data and then the load of the result register; with active_blocks zero the
// scan is skipped and the request goes straight to the result step like a load.
// One request is in work at a time; the result register holds a finished result
// until it is taken, and a result held back by out_ready stalls the next one in
// its final step.
`default_nettype none
module smallest_fit_partition_allocator_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           mode,
  input  wire logic [sfpa_pkg::INDEX_W-1:0]   entry_index,
  input  wire logic [sfpa_pkg::SIZE_W-1:0]    size,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [sfpa_pkg::STATUS_W-1:0]  status,
  output logic      [sfpa_pkg::INDEX_W-1:0]   granted_index,
  output logic      [sfpa_pkg::SIZE_W-1:0]    leftover,
  input  wire logic                           cfg_write_en,
  input  wire logic [sfpa_pkg::ACTIVE_W-1:0]  cfg_write_data
);

  sfpa_pkg::sfpa_cmd_t  cmd;
  sfpa_pkg::sfpa_stat_t stat;

  sfpa_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode    (mode),
    .stat    (stat),
    .cmd     (cmd)
  );

  sfpa_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .mode          (mode),
    .entry_index   (entry_index),
    .size          (size),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .granted_index (granted_index),
    .leftover      (leftover)
  );

endmodule
`default_nettype wire

FILE: test/smallest_fit_partition_allocator_core_tb.sv
// Self-checking testbench for the smallest-fit partition allocator core.
module smallest_fit_partition_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [sfpa_pkg::STATUS_W-1:0] status;
    logic [sfpa_pkg::INDEX_W-1:0]  granted_index;
    logic [sfpa_pkg::SIZE_W-1:0]   leftover;
  } alloc_result_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic                          mode;
  logic [sfpa_pkg::INDEX_W-1:0]  entry_index;
  logic [sfpa_pkg::SIZE_W-1:0]   size;
  logic                          out_valid;
  logic                          out_ready;
  logic [sfpa_pkg::STATUS_W-1:0] status;
  logic [sfpa_pkg::INDEX_W-1:0]  granted_index;
  logic [sfpa_pkg::SIZE_W-1:0]   leftover;
  logic                          cfg_write_en;
  logic [sfpa_pkg::ACTIVE_W-1:0] cfg_write_data;

  // Shadow of the partition table and the active count
  logic [sfpa_pkg::SIZE_W-1:0]      part_capacity [sfpa_pkg::BLOCK_COUNT];
  logic [sfpa_pkg::BLOCK_COUNT-1:0] part_loaded;
  logic [sfpa_pkg::BLOCK_COUNT-1:0] part_occupied;
  logic [sfpa_pkg::ACTIVE_W-1:0]    active_count;

  alloc_result_t pending_results[$];
  int            mismatch_count;
  int            result_seq;
  int            send_idle_pct;
  int            recv_stall_pct;

  smallest_fit_partition_allocator_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .entry_index    (entry_index),
    .size           (size),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .granted_index  (granted_index),
    .leftover       (leftover),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("smallest_fit_partition_allocator_core_tb failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < 50) $display("MISMATCH result %0d: %s", result_seq, what);
    mismatch_count++;
  endtask

  // Outcome of one request; updates the shadow table as the block should
  function automatic alloc_result_t predict_outcome(
      input logic                         req_mode,
      input logic [sfpa_pkg::INDEX_W-1:0] idx,
      input logic [sfpa_pkg::SIZE_W-1:0]  req_size);
    alloc_result_t res;
    int            limit;
    int            best;
    bit            found;
    res = '0;
    if (req_mode == sfpa_pkg::MODE_LOAD) begin
      part_capacity[idx] = req_size;
      part_loaded[idx]   = 1'b1;
      part_occupied[idx] = 1'b0;
      res.status = sfpa_pkg::STATUS_LOAD_DONE;
      return res;
    end
    // counts above the table size saturate
    limit = (active_count > sfpa_pkg::BLOCK_COUNT) ? sfpa_pkg::BLOCK_COUNT
                                                   : int'(active_count);
    best  = 0;
    found = 1'b0;
    for (int i = 0; i < limit; i++) begin
      if (part_loaded[i] && !part_occupied[i] && part_capacity[i] >= req_size &&
          (!found || part_capacity[i] < part_capacity[best])) begin
        best  = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      res.status = sfpa_pkg::STATUS_NO_FIT;
      return res;
    end
    part_occupied[best] = 1'b1;
    res.status        = sfpa_pkg::STATUS_GRANTED;
    res.granted_index = sfpa_pkg::INDEX_W'(best);
    res.leftover      = part_capacity[best] - req_size;
    return res;
  endfunction

  function automatic void set_idle_mode(input idle_mode_t idling);
    case (idling)
      IDLE_NONE: begin
        send_idle_pct = 0;  recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 54; recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;  recv_stall_pct = 54;
      end
      default: begin
        send_idle_pct = 38; recv_stall_pct = 38;
      end
    endcase
  endfunction

  // Present one request, hold it until taken, then queue its expected result.
  // Valid stays high after acceptance so back-to-back requests need no toggle.
  task automatic send_request(input logic                         req_mode,
                              input logic [sfpa_pkg::INDEX_W-1:0] idx,
                              input logic [sfpa_pkg::SIZE_W-1:0]  req_size);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    mode        <= req_mode;
    entry_index <= idx;
    size        <= req_size;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_outcome(req_mode, idx, req_size));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Register writes only with nothing in flight
  task automatic write_active_count(input logic [sfpa_pkg::ACTIVE_W-1:0] value);
    wait_idle();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    active_count = value;
  endtask

  // Capacities: small values for ties, both extremes, or anything
  function automatic logic [sfpa_pkg::SIZE_W-1:0] pick_capacity();
    logic [sfpa_pkg::SIZE_W-1:0] value;
    value = sfpa_pkg::SIZE_W'($urandom());
    case ($urandom_range(3))
      0: value[sfpa_pkg::SIZE_W-1:4] = '0;
      1: value = {sfpa_pkg::SIZE_W{value[0]}};
      default: ;
    endcase
    return value;
  endfunction

  // Request sizes: mostly aimed at or under a capacity in the table
  function automatic logic [sfpa_pkg::SIZE_W-1:0] pick_request_size();
    logic [sfpa_pkg::SIZE_W-1:0] value;
    int                          pick;
    int                          slot;
    value = sfpa_pkg::SIZE_W'($urandom());
    pick  = $urandom_range(9);
    slot  = $urandom_range(sfpa_pkg::BLOCK_COUNT - 1);
    if (pick < 3) value[sfpa_pkg::SIZE_W-1:4] = '0;
    else if (pick < 7 && part_loaded[slot]) value = part_capacity[slot] >> $urandom_range(2);
    else if (pick == 9) value = {sfpa_pkg::SIZE_W{value[0]}};
    return value;
  endfunction

  // Result checker and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("no request pending, got status %0d", status));
        end else begin
          automatic alloc_result_t want = pending_results.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", status, want.status));
          if (granted_index !== want.granted_index)
            report_mismatch($sformatf("granted_index %0d, want %0d",
                                      granted_index, want.granted_index));
          if (leftover !== want.leftover)
            report_mismatch($sformatf("leftover %0d, want %0d", leftover, want.leftover));
        end
        result_seq++;
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Hand-picked table: exact fits, ties, zero-size request, reload of a taken entry
  task automatic test_directed_cases();
    set_idle_mode(IDLE_NONE);
    // nothing takes part with the reset count
    send_request(sfpa_pkg::MODE_ALLOC, '0, '0);
    send_request(sfpa_pkg::MODE_LOAD, 6'd0, 16'hFFFF);
    send_request(sfpa_pkg::MODE_LOAD, 6'd1, 16'd0);
    send_request(sfpa_pkg::MODE_LOAD, 6'd2, 16'd100);
    send_request(sfpa_pkg::MODE_LOAD, 6'd3, 16'd100);
    send_request(sfpa_pkg::MODE_LOAD, 6'd4, 16'd50);
    send_request(sfpa_pkg::MODE_LOAD, 6'd5, 16'd200);
    // stored beyond the active count
    send_request(sfpa_pkg::MODE_LOAD, 6'd63, 16'd1);
    write_active_count(7'd6);
    send_request(sfpa_pkg::MODE_ALLOC, 6'd63, 16'hFFFF);
    send_request(sfpa_pkg::MODE_ALLOC, '0, 16'd100);
    send_request(sfpa_pkg::MODE_ALLOC, '0, 16'd100);
    send_request(sfpa_pkg::MODE_ALLOC, '0, 16'd60);
    send_request(sfpa_pkg::MODE_ALLOC, '0, 16'd0);
    send_request(sfpa_pkg::MODE_ALLOC, '0, 16'd1);
    send_request(sfpa_pkg::MODE_ALLOC, '0, 16'd0);
    send_request(sfpa_pkg::MODE_LOAD, 6'd2, 16'd7);
    send_request(sfpa_pkg::MODE_ALLOC, '0, 16'd5);
    send_request(sfpa_pkg::MODE_ALLOC, '0, 16'd1);
  endtask

  // Load every entry so any active count scans written entries only
  task automatic test_table_fill();
    set_idle_mode(IDLE_BOTH);
    for (int i = sfpa_pkg::BLOCK_COUNT - 1; i >= 0; i--)
      send_request(sfpa_pkg::MODE_LOAD, sfpa_pkg::INDEX_W'(i), pick_capacity());
  endtask

  // Count saturation, full table, empty range
  task automatic test_active_count_extremes();
    set_idle_mode(IDLE_NONE);
    write_active_count(7'd127);
    send_request(sfpa_pkg::MODE_LOAD, 6'd63, 16'd2);
    send_request(sfpa_pkg::MODE_ALLOC, '0, 16'd2);
    send_request(sfpa_pkg::MODE_ALLOC, '0, 16'hFFFF);
    write_active_count(7'd64);
    send_request(sfpa_pkg::MODE_ALLOC, '0, 16'd0);
    write_active_count(7'd65);
    send_request(sfpa_pkg::MODE_ALLOC, '0, 16'd0);
    write_active_count(7'd0);
    send_request(sfpa_pkg::MODE_ALLOC, '0, 16'd0);
    write_active_count(7'd1);
    send_request(sfpa_pkg::MODE_LOAD, 6'd0, 16'hFFFF);
    send_request(sfpa_pkg::MODE_ALLOC, '0, 16'hFFFF);
  endtask

  task automatic run_traffic_phase(input int active, input idle_mode_t idling,
                                   input int items);
    logic [sfpa_pkg::INDEX_W-1:0] idx;
    int                           span;
    write_active_count(sfpa_pkg::ACTIVE_W'(active));
    set_idle_mode(idling);
    span = (active > sfpa_pkg::BLOCK_COUNT) ? sfpa_pkg::BLOCK_COUNT : active;
    for (int n = 0; n < items; n++) begin
      // loads mostly land inside the active range so freed entries get reused
      idx = sfpa_pkg::INDEX_W'($urandom());
      if (span > 0 && $urandom_range(3) != 0)
        idx = sfpa_pkg::INDEX_W'($urandom_range(span - 1));
      if ($urandom_range(99) < 45)
        send_request(sfpa_pkg::MODE_LOAD, idx, pick_capacity());
      else
        send_request(sfpa_pkg::MODE_ALLOC, sfpa_pkg::INDEX_W'($urandom()),
                     pick_request_size());
    end
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(64, IDLE_NONE, 150);
    run_traffic_phase(127, IDLE_SENDER, 150);
    run_traffic_phase(0, IDLE_RECEIVER, 40);
    run_traffic_phase(1, IDLE_BOTH, 80);
    run_traffic_phase(5, IDLE_NONE, 120);
    run_traffic_phase(17, IDLE_SENDER, 130);
    run_traffic_phase(33, IDLE_RECEIVER, 130);
    run_traffic_phase(64, IDLE_BOTH, 150);
    run_traffic_phase(100, IDLE_NONE, 100);
    run_traffic_phase($urandom_range(127, 2), IDLE_BOTH, 100);
    run_traffic_phase(64, IDLE_RECEIVER, 100);
  endtask

  initial begin
    in_valid       = 1'b0;
    mode           = sfpa_pkg::MODE_LOAD;
    entry_index    = '0;
    size           = '0;
    out_ready      = 1'b0;
    cfg_write_en   = 1'b0;
    cfg_write_data = '0;
    part_loaded    = '0;
    part_occupied  = '0;
    active_count   = '0;
    mismatch_count = 0;
    result_seq     = 0;
    set_idle_mode(IDLE_NONE);
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_table_fill();
    test_active_count_extremes();
    test_random_traffic();

    // drain, then watch for stray results over one full scan
    wait_idle();
    repeat (80) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("smallest_fit_partition_allocator_core_tb passed");
    end else begin
      $display("smallest_fit_partition_allocator_core_tb failed");
    end
    $finish;
  end

endmodule
